// ===== rtl/swt_pkg.sv =====
// ----------------------------------------------------------------------------
// swt_pkg: shared types and constants for the shell word tokeniser
// Holds the byte codes the tokeniser recognises, the quote kind, the
// tokeniser state and the per-byte decision record.
// ----------------------------------------------------------------------------
package swt_pkg;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;

  typedef enum logic [1:0] {
    QK_NONE   = 2'd0,
    QK_SINGLE = 2'd1,
    QK_DOUBLE = 2'd2
  } quote_kind_t;

  typedef struct packed {
    quote_kind_t quote_kind;
    logic        escape_pending;
    logic        word_open;
  } tok_state_t;

  typedef struct packed {
    logic       has_result;
    logic [7:0] out_char;
    logic       char_valid;
    logic       word_end;
  } tok_result_t;

endpackage

// ===== rtl/swt_step.sv =====
// ----------------------------------------------------------------------------
// swt_step: per-byte tokeniser decision
// Classifies one byte against the current state and produces the next
// state together with the result beat, if any.
// ----------------------------------------------------------------------------
module swt_step (
  input  swt_pkg::tok_state_t  state,
  input  logic [7:0]           ch,
  input  logic                 last,
  output swt_pkg::tok_state_t  state_next,
  output swt_pkg::tok_result_t result
);
  import swt_pkg::*;

  logic       is_ws;
  logic       append;
  logic       close;
  logic       word_open_mid;
  logic [7:0] close_quote;
  tok_state_t mid;

  assign is_ws = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
  assign close_quote = (state.quote_kind == QK_SINGLE) ? CH_SQUOTE : CH_DQUOTE;

  always_comb begin
    mid    = state;
    append = 1'b0;
    close  = 1'b0;
    priority if (state.escape_pending) begin
      mid.escape_pending = 1'b0;
      append             = 1'b1;
    end else if ((ch == CH_BACKSLASH) && !last) begin
      mid.escape_pending = 1'b1;
    end else if (state.quote_kind != QK_NONE) begin
      if (ch == close_quote) begin
        mid.quote_kind = QK_NONE;
      end else begin
        append = 1'b1;
      end
    end else if (ch == CH_SQUOTE) begin
      mid.quote_kind = QK_SINGLE;
    end else if (ch == CH_DQUOTE) begin
      mid.quote_kind = QK_DOUBLE;
    end else if (is_ws) begin
      close = state.word_open;
    end else begin
      append = 1'b1;
    end
  end

  assign word_open_mid = state.word_open | append;

  always_comb begin
    state_next = mid;
    state_next.word_open = word_open_mid & ~close;
    if (last) begin
      state_next.quote_kind     = QK_NONE;
      state_next.escape_pending = 1'b0;
      state_next.word_open      = 1'b0;
    end
  end

  assign result.has_result = append | close | (last & word_open_mid);
  assign result.out_char   = append ? ch : 8'h00;
  assign result.char_valid = append;
  assign result.word_end   = close | (last & word_open_mid);

endmodule

// ===== rtl/shell_word_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// A result beat appears in the output register in the cycle after the byte that causes it.
// One byte per cycle while the output register is free; the state update is a single flag step.
// A byte is taken whenever the output register is empty or being emptied.
// Reset (rst, synchronous) clears the quote, escape and word flags and
// empties the output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
// shell_word_tokenizer_top: shell-style word splitter
// Takes a command line one byte per beat, with a flag on the final byte,
// and emits one beat per appended word byte or word end.
// ----------------------------------------------------------------------------
module shell_word_tokenizer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] ch,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       char_valid,
  output logic       word_end
);
  import swt_pkg::*;

  // Tokeniser state: open quote kind, pending backslash and word-open flag.
  tok_state_t  state;
  tok_state_t  state_next;
  tok_result_t result;
  logic        in_accept;
  logic        out_free;

  // The output register frees up in the same cycle its beat is taken, so a
  // new byte can enter every cycle while the downstream side keeps up.
  assign out_free  = ~out_valid | ~out_stall;
  assign in_stall  = ~out_free;
  assign in_accept = in_valid & out_free;

  swt_step u_step (
    .state      (state),
    .ch         (ch),
    .last       (last),
    .state_next (state_next),
    .result     (result)
  );

  // State advances only on an accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.quote_kind     <= QK_NONE;
      state.escape_pending <= 1'b0;
      state.word_open      <= 1'b0;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  // Result register. Bytes that neither append nor close a word leave it
  // empty, so those beats produce nothing downstream.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_accept & result.has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && out_free) begin
      out_char   <= result.out_char;
      char_valid <= result.char_valid;
      word_end   <= result.word_end;
    end
  end

  // Every delivered beat carries either a byte or a word end.
  a_beat_has_content: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_valid || word_end))
    else $error("result beat with neither byte nor word end");

  // A beat without a byte carries a zero byte.
  a_zero_char: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !char_valid) |-> (out_char == 8'h00))
    else $error("non-zero byte on a beat without a byte");

  // The final byte of a line leaves all tokeniser state clear.
  a_line_end_clears: assert property (@(posedge clk) disable iff (rst)
    (in_accept && last) |=> (state.quote_kind == QK_NONE &&
                            !state.escape_pending && !state.word_open))
    else $error("state not cleared after final byte");

  // The final byte of a line with an open word always yields a word end.
  a_line_end_closes: assert property (@(posedge clk) disable iff (rst)
    (in_accept && last && state.word_open) |=> (out_valid && word_end))
    else $error("open word not closed at end of line");

endmodule
